FILE: src/weighted_least_connection_select_core_defines.svh
// Assertion macros for the weighted least-connection selector.
// Used by the top level; expects clk and arst_n in scope.
`ifndef WEIGHTED_LEAST_CONNECTION_SELECT_CORE_DEFINES_SVH
`define WEIGHTED_LEAST_CONNECTION_SELECT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold on every clock edge outside reset
`define WLCS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("wlcs assertion failed");
// Trigger in one cycle implies consequence in the next
`define WLCS_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("wlcs assertion failed");
`else
`define WLCS_ASSERT(label, prop)
`define WLCS_ASSERT_NEXT(label, trig, cons)
`endif

`endif

FILE: src/wlcs_pkg.sv
// Shared types and constants for the weighted least-connection selector.
// No dependencies.
`timescale 1ns / 1ps

package wlcs_pkg;

	localparam int DEFAULT_MAX_ENTRIES = 64;

	// Field widths
	localparam int INDEX_W  = 6;
	localparam int WEIGHT_W = 16;
	localparam int COUNT_W  = 16;
	localparam int DCOUNT_W = 7;
	localparam int LOAD_W   = 25;
	localparam int LOAD_SHIFT = 8;
	localparam int PROD_W   = LOAD_W + WEIGHT_W;
	localparam int WORD_W   = WEIGHT_W + LOAD_W;

	// Request commands
	localparam logic CMD_UPDATE   = 1'b0;
	localparam logic CMD_SCHEDULE = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_en;        // table write this cycle
		logic wr_clear;     // write zeros (reset sweep)
		logic rd_en;        // table read this cycle
		logic scan_start;   // drop current best before a scan
		logic load_result;  // capture best into the result register
	} ctrl_cmd_t;

endpackage

FILE: src/wlcs_if.sv
// Request and result channel interfaces (valid/ready) for the selector.
// Depends on wlcs_pkg.
`timescale 1ns / 1ps

interface wlcs_req_if
	import wlcs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                command;
	logic [INDEX_W-1:0]  entry_index;
	logic [WEIGHT_W-1:0] weight;
	logic [COUNT_W-1:0]  active_count;
	logic [COUNT_W-1:0]  inactive_count;

	modport source (output valid, command, entry_index, weight, active_count,
		inactive_count, input ready);
	modport sink (input valid, command, entry_index, weight, active_count,
		inactive_count, output ready);
endinterface

interface wlcs_res_if
	import wlcs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               found;
	logic [INDEX_W-1:0] chosen_index;
	logic [LOAD_W-1:0]  chosen_load;

	modport source (output valid, found, chosen_index, chosen_load, input ready);
	modport sink (input valid, found, chosen_index, chosen_load, output ready);
endinterface

FILE: src/wlcs_ctrl.sv
// Controller: reset clear sweep, request handshake, scan sequencing, result valid.
// Depends on wlcs_pkg.
`timescale 1ns / 1ps

module wlcs_ctrl
	import wlcs_pkg::*;
#(
	parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
	localparam int IDX_W = $clog2(MAX_ENTRIES),
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                req_command,
	input  logic [INDEX_W-1:0]  req_entry_index,
	output logic                res_valid,
	input  logic                res_ready,
	input  logic                cfg_wr_en,
	input  logic [DCOUNT_W-1:0] cfg_wr_data,
	output ctrl_cmd_t           cmd,
	output logic [IDX_W-1:0]    wr_addr,
	output logic [IDX_W-1:0]    rd_addr
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    n_q;
	logic [DCOUNT_W-1:0] dest_count_q;
	logic                out_valid_q;

	logic             accept;
	logic             idx_ok;
	logic             slot_free;
	logic             scan_done;
	logic             clear_last;
	logic [CNT_W-1:0] n_clamped;

	// Decode
	assign req_ready  = (state_q == ST_IDLE);
	assign accept     = req_valid && req_ready;
	assign idx_ok     = (32'(req_entry_index) < MAX_ENTRIES);
	assign slot_free  = !out_valid_q || res_ready;
	assign scan_done  = (cnt_q == n_q);
	assign clear_last = (cnt_q[IDX_W-1:0] == IDX_W'(MAX_ENTRIES - 1));
	assign n_clamped  = (32'(dest_count_q) > MAX_ENTRIES) ?
		CNT_W'(MAX_ENTRIES) : CNT_W'(dest_count_q);
	assign res_valid  = out_valid_q;

	// Datapath commands
	always_comb begin
		cmd             = '0;
		cmd.wr_clear    = (state_q == ST_CLEAR);
		cmd.wr_en       = (state_q == ST_CLEAR) ||
			(accept && req_command == CMD_UPDATE && idx_ok);
		cmd.rd_en       = (state_q == ST_SCAN) && !scan_done;
		cmd.scan_start  = accept && req_command == CMD_SCHEDULE;
		cmd.load_result = (state_q == ST_FINISH) && slot_free;
		wr_addr = (state_q == ST_CLEAR) ? cnt_q[IDX_W-1:0] : IDX_W'(req_entry_index);
		rd_addr = cnt_q[IDX_W-1:0];
	end

	// State, counters, config and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			n_q          <= '0;
			dest_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dest_count_q <= cfg_wr_data;
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.scan_start) begin
						cnt_q   <= '0;
						n_q     <= n_clamped;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: src/wlcs_datapath.sv
// Datapath: entry table memory, registered read, weighted-load compare, result register.
// Depends on wlcs_pkg.
`timescale 1ns / 1ps

module wlcs_datapath
	import wlcs_pkg::*;
#(
	parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
	localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	input  logic [IDX_W-1:0]    wr_addr,
	input  logic [IDX_W-1:0]    rd_addr,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic [COUNT_W-1:0]  active_count,
	input  logic [COUNT_W-1:0]  inactive_count,
	output logic                found,
	output logic [INDEX_W-1:0]  chosen_index,
	output logic [LOAD_W-1:0]   chosen_load
);

	// Each word holds {weight, load}; load is precomputed on update
	logic [WORD_W-1:0] mem_q [MAX_ENTRIES];

	logic [WORD_W-1:0]   rd_data_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                rd_valid_s1;

	logic                have_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [LOAD_W-1:0]   best_load_q;
	logic [WEIGHT_W-1:0] best_w_q;

	logic                res_found_q;
	logic [INDEX_W-1:0]  res_index_q;
	logic [LOAD_W-1:0]   res_load_q;

	logic [LOAD_W-1:0]   new_load;
	logic [WORD_W-1:0]   wr_word;
	logic [WEIGHT_W-1:0] w_s1;
	logic [LOAD_W-1:0]   ld_s1;
	logic [PROD_W-1:0]   prod_cur;
	logic [PROD_W-1:0]   prod_new;
	logic                take;

	// Load of the entry being written
	assign new_load = (LOAD_W'(active_count) << LOAD_SHIFT) + LOAD_W'(inactive_count);
	assign wr_word  = cmd.wr_clear ? '0 : {weight, new_load};

	// Table write port and registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_word;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
		end
	end

	// Cross-multiplied compare: strict, so ties keep the earlier entry
	assign w_s1     = rd_data_s1[LOAD_W +: WEIGHT_W];
	assign ld_s1    = rd_data_s1[LOAD_W-1:0];
	assign prod_cur = PROD_W'(best_load_q) * PROD_W'(w_s1);
	assign prod_new = PROD_W'(ld_s1) * PROD_W'(best_w_q);
	assign take     = rd_valid_s1 && (w_s1 != '0) && (!have_q || prod_cur > prod_new);

	// Running best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.scan_start) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= rd_idx_s1;
			best_load_q <= ld_s1;
			best_w_q    <= w_s1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_found_q <= have_q;
			res_index_q <= have_q ? INDEX_W'(best_idx_q) : '0;
			res_load_q  <= have_q ? best_load_q : '0;
		end
	end

	assign found        = res_found_q;
	assign chosen_index = res_index_q;
	assign chosen_load  = res_load_q;

endmodule

FILE: src/weighted_least_connection_select_core.sv
// Weighted least-connection selector, top level.
// Update request: written on accept, no result. Schedule request: scans entries 0..n-1,
// n = min(dest_count, MAX_ENTRIES), and loads the result once the output slot is free;
// requests held off meanwhile. Scan: one table entry per cycle via the single read port.
// Reset: a clear sweep writes zeros to all MAX_ENTRIES entries, one per cycle, with
// requests held off; configuration writes are taken throughout. dest_count resets to 0.
`timescale 1ns / 1ps
`include "weighted_least_connection_select_core_defines.svh"

module weighted_least_connection_select_core
	import wlcs_pkg::*;
#(
	parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
	input  logic                clk,
	input  logic                arst_n,
	wlcs_req_if.sink            req,
	wlcs_res_if.source          res,
	input  logic                cfg_wr_en,
	input  logic [DCOUNT_W-1:0] cfg_wr_data
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);

	ctrl_cmd_t        cmd;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;

	// Controller
	wlcs_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req.valid),
		.req_ready      (req.ready),
		.req_command    (req.command),
		.req_entry_index(req.entry_index),
		.res_valid      (res.valid),
		.res_ready      (res.ready),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.cmd            (cmd),
		.wr_addr        (wr_addr),
		.rd_addr        (rd_addr)
	);

	// Datapath
	wlcs_datapath #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.rd_addr       (rd_addr),
		.weight        (req.weight),
		.active_count  (req.active_count),
		.inactive_count(req.inactive_count),
		.found         (res.found),
		.chosen_index  (res.chosen_index),
		.chosen_load   (res.chosen_load)
	);

	// Checks
	`WLCS_ASSERT(a_no_rd_wr_overlap, !(cmd.wr_en && cmd.rd_en))
	`WLCS_ASSERT(a_no_accept_in_scan, !(req.ready && cmd.rd_en))
	`WLCS_ASSERT(a_none_found_zero, !res.valid || res.found || !(|{res.chosen_index, res.chosen_load}))
	`WLCS_ASSERT_NEXT(a_result_after_load, cmd.load_result, res.valid)

endmodule
